// ----- rtl/scx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scx_pkg: shared types and constants of the byte stream cipher
// Holds the block constants, register indexes, round step coding and the
// command bundle that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package scx_pkg;

	typedef logic [31:0] word_t;
	typedef logic [63:0] cfg_data_t;
	typedef logic [2:0]  cfg_idx_t;
	typedef logic [5:0]  pos_t;
	typedef logic [7:0]  byte_t;

	localparam int unsigned WORDS = 16;

	// The four fixed words that open every block ("expand 32-byte k").
	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;

	localparam int unsigned ROT_A = 16;
	localparam int unsigned ROT_B = 12;
	localparam int unsigned ROT_C = 8;
	localparam int unsigned ROT_D = 7;

	// Ten double rounds, eight add-xor-rotate steps each.
	localparam int unsigned DOUBLE_ROUNDS = 10;
	localparam int unsigned NUM_STEPS     = DOUBLE_ROUNDS * 8;
	localparam int unsigned STEP_W        = $clog2(NUM_STEPS);
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t LAST_STEP = step_t'(NUM_STEPS - 1);

	localparam pos_t LAST_POS = 6'd63;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_KEY0   = 3'd0;
	localparam cfg_idx_t CFG_KEY1   = 3'd1;
	localparam cfg_idx_t CFG_KEY2   = 3'd2;
	localparam cfg_idx_t CFG_KEY3   = 3'd3;
	localparam cfg_idx_t CFG_NONCE0 = 3'd4;
	localparam cfg_idx_t CFG_NONCE1 = 3'd5;
	localparam cfg_idx_t CFG_START  = 3'd6;

	// Sub-step of a quarter round.
	localparam logic [1:0] SUB_AB16 = 2'd0;
	localparam logic [1:0] SUB_CD12 = 2'd1;
	localparam logic [1:0] SUB_AB8  = 2'd2;
	localparam logic [1:0] SUB_CD7  = 2'd3;

	typedef struct packed {
		logic       load;        // load the state words for a new block
		logic       load_start;  // take the counter from the start register
		logic       round;       // run one step on all four lanes
		logic [1:0] sub;         // which step of the quarter round
		logic       diag;        // diagonal half of the double round
		logic       finish;      // add the input state back, bump the counter
		logic       take;        // an item is accepted this cycle
		pos_t       pos;         // keystream byte for the accepted item
	} cmd_t;

	function automatic word_t rotl(input word_t v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

endpackage
`default_nettype wire

// ----- rtl/scx_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scx_if: channel interfaces of the byte stream cipher
// Input byte channel, result channel and configuration write channel, each
// with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface scx_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface scx_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  result_byte;
	logic        result_last;
	modport source(output valid, output result_byte, output result_last, input ready);
	modport sink(input valid, input result_byte, input result_last, output ready);
endinterface

interface scx_cfg_if;
	logic                 valid;
	logic                 ready;
	scx_pkg::cfg_idx_t    index;
	scx_pkg::cfg_data_t   data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/scx_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scx_datapath: key schedule registers, block state and byte output
// Holds the configuration, the sixteen state words that become the
// keystream block, the block counter and the registered result.
// ----------------------------------------------------------------------------
module scx_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  scx_pkg::cfg_idx_t   cfg_index,
	input  scx_pkg::cfg_data_t  cfg_data,
	input  scx_pkg::cmd_t       cmd,
	input  wire [7:0]           in_data,
	input  wire                 in_last,
	output logic [7:0]          result_byte,
	output logic                result_last
);

	scx_pkg::cfg_data_t key0_q, key1_q, key2_q, key3_q, nonce0_q;
	scx_pkg::word_t     nonce1_q, start_q, ctr_q;
	scx_pkg::word_t     w_q    [scx_pkg::WORDS];
	scx_pkg::word_t     w_rnd  [scx_pkg::WORDS];
	scx_pkg::word_t     init_w [scx_pkg::WORDS];
	scx_pkg::word_t     ctr_sel;
	scx_pkg::word_t     init_ctr;
	scx_pkg::word_t     ks_word;
	scx_pkg::byte_t     ks_byte;
	scx_pkg::byte_t     result_byte_q;
	logic               result_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q   <= '0;
			key1_q   <= '0;
			key2_q   <= '0;
			key3_q   <= '0;
			nonce0_q <= '0;
			nonce1_q <= '0;
			start_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scx_pkg::CFG_KEY0:   key0_q   <= cfg_data;
				scx_pkg::CFG_KEY1:   key1_q   <= cfg_data;
				scx_pkg::CFG_KEY2:   key2_q   <= cfg_data;
				scx_pkg::CFG_KEY3:   key3_q   <= cfg_data;
				scx_pkg::CFG_NONCE0: nonce0_q <= cfg_data;
				scx_pkg::CFG_NONCE1: nonce1_q <= cfg_data[31:0];
				scx_pkg::CFG_START:  start_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign ctr_sel  = cmd.load_start ? start_q : ctr_q;
	assign init_ctr = cmd.load ? ctr_sel : ctr_q;

	always_comb begin
		init_w[0]  = scx_pkg::SIGMA0;
		init_w[1]  = scx_pkg::SIGMA1;
		init_w[2]  = scx_pkg::SIGMA2;
		init_w[3]  = scx_pkg::SIGMA3;
		init_w[4]  = key0_q[31:0];
		init_w[5]  = key0_q[63:32];
		init_w[6]  = key1_q[31:0];
		init_w[7]  = key1_q[63:32];
		init_w[8]  = key2_q[31:0];
		init_w[9]  = key2_q[63:32];
		init_w[10] = key3_q[31:0];
		init_w[11] = key3_q[63:32];
		init_w[12] = init_ctr;
		init_w[13] = nonce0_q[31:0];
		init_w[14] = nonce0_q[63:32];
		init_w[15] = nonce1_q;
	end

	// Four quarter-round lanes, one add-xor-rotate step per cycle each.
	// The diagonal half shifts lanes b, c and d by one, two and three columns.
	always_comb begin
		w_rnd = w_q;
		for (int l = 0; l < 4; l++) begin
			logic [1:0]     lb, lc, ld;
			logic [3:0]     ia, ib, ic, id;
			scx_pkg::word_t sum;
			lb  = 2'(l) + {1'b0, cmd.diag};
			lc  = 2'(l) + {cmd.diag, 1'b0};
			ld  = 2'(l) + {cmd.diag, cmd.diag};
			ia  = {2'd0, 2'(l)};
			ib  = {2'd1, lb};
			ic  = {2'd2, lc};
			id  = {2'd3, ld};
			sum = '0;
			unique case (cmd.sub)
				scx_pkg::SUB_AB16: begin
					sum       = w_q[ia] + w_q[ib];
					w_rnd[ia] = sum;
					w_rnd[id] = scx_pkg::rotl(w_q[id] ^ sum, scx_pkg::ROT_A);
				end
				scx_pkg::SUB_CD12: begin
					sum       = w_q[ic] + w_q[id];
					w_rnd[ic] = sum;
					w_rnd[ib] = scx_pkg::rotl(w_q[ib] ^ sum, scx_pkg::ROT_B);
				end
				scx_pkg::SUB_AB8: begin
					sum       = w_q[ia] + w_q[ib];
					w_rnd[ia] = sum;
					w_rnd[id] = scx_pkg::rotl(w_q[id] ^ sum, scx_pkg::ROT_C);
				end
				scx_pkg::SUB_CD7: begin
					sum       = w_q[ic] + w_q[id];
					w_rnd[ic] = sum;
					w_rnd[ib] = scx_pkg::rotl(w_q[ib] ^ sum, scx_pkg::ROT_D);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= init_w;
		end else if (cmd.round) begin
			w_q <= w_rnd;
		end else if (cmd.finish) begin
			for (int i = 0; i < scx_pkg::WORDS; i++) begin
				w_q[i] <= w_q[i] + init_w[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (cmd.load) begin
			ctr_q <= ctr_sel;
		end else if (cmd.finish) begin
			ctr_q <= ctr_q + 32'd1;
		end
	end

	assign ks_word = w_q[cmd.pos[5:2]];
	assign ks_byte = ks_word[{cmd.pos[1:0], 3'b000} +: 8];

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			result_byte_q <= in_data ^ ks_byte;
			result_last_q <= in_last;
		end
	end

	assign result_byte = result_byte_q;
	assign result_last = result_last_q;

endmodule
`default_nettype wire

// ----- rtl/scx_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scx_ctrl: sequencer of the byte stream cipher
// Tracks message and keystream state, runs the block generation steps and
// drives the handshakes of the byte and result channels.
// ----------------------------------------------------------------------------
module scx_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	input  wire             in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  wire             out_ready,
	output scx_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_STREAM = 2'd0;
	localparam logic [1:0] ST_ROUND  = 2'd1;
	localparam logic [1:0] ST_FINAL  = 2'd2;

	logic [1:0]        state_q;
	scx_pkg::step_t    step_q;
	scx_pkg::pos_t     pos_q;
	logic              have_block_q;
	logic              msg_active_q;
	logic              out_valid_q;
	logic              take;
	logic              start_gen;

	assign in_ready  = (state_q == ST_STREAM) && have_block_q && (!out_valid_q || out_ready);
	assign take      = in_valid && in_ready;
	assign start_gen = (state_q == ST_STREAM) && in_valid && !have_block_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = start_gen;
		cmd.load_start = !msg_active_q;
		cmd.round      = (state_q == ST_ROUND);
		cmd.sub        = step_q[1:0];
		cmd.diag       = step_q[2];
		cmd.finish     = (state_q == ST_FINAL);
		cmd.take       = take;
		cmd.pos        = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_STREAM;
			step_q       <= '0;
			pos_q        <= '0;
			have_block_q <= 1'b0;
			msg_active_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_STREAM: begin
					if (start_gen) begin
						state_q <= ST_ROUND;
						step_q  <= '0;
					end
				end
				ST_ROUND: begin
					step_q <= step_q + 1'b1;
					if (step_q == scx_pkg::LAST_STEP) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					state_q      <= ST_STREAM;
					have_block_q <= 1'b1;
					msg_active_q <= 1'b1;
				end
				default: begin
					state_q <= ST_STREAM;
				end
			endcase
			if (take) begin
				if (in_last) begin
					pos_q        <= '0;
					have_block_q <= 1'b0;
					msg_active_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == scx_pkg::LAST_POS) begin
						have_block_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A last byte ends the message and drops the held block.
	a_last_ends_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_last) |=> (!have_block_q && !msg_active_q && pos_q == '0))
		else $error("message state not cleared after last byte");

	// The final byte of a block forces a new block for the next item.
	a_block_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(take && pos_q == scx_pkg::LAST_POS) |=> !have_block_q)
		else $error("block still marked valid after its last byte");

	// No item is taken while a block is being generated.
	a_no_take_in_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_STREAM) |-> !take)
		else $error("item accepted during block generation");

	// Finishing a block leaves a usable keystream in an open message.
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) |=> (have_block_q && msg_active_q && state_q == ST_STREAM))
		else $error("block finish did not publish keystream");

endmodule
`default_nettype wire

// ----- rtl/stream_cipher_byte_xor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stream_cipher_byte_xor: ChaCha20 byte stream encryptor and decryptor
// XORs each message byte with the next byte of the 20-round keystream.
// ----------------------------------------------------------------------------
// A byte inside a generated block is accepted and its result is registered
// for the next cycle. Block generation loads the state words, runs the lane
// steps of the twenty rounds and adds the input state back; it runs before
// the first byte of a message and before every 64th byte after it.
// Throughput: one byte per cycle in a block when the result channel is free;
// lower over a long message, set by the four shared quarter-round lanes.
// Reset clears configuration, block counter and message state; no clearing pass.
// ----------------------------------------------------------------------------
module stream_cipher_byte_xor (
	input  wire             clk,
	input  wire             arst_n,
	scx_cfg_if.sink         cfg,
	scx_in_if.sink          byte_stream,
	scx_out_if.source       result_stream
);

	// Command bundle from the sequencer to the datapath.
	scx_pkg::cmd_t cmd;

	// Configuration writes are always accepted. The user must issue them only while
	// the block is idle, which the block does not enforce, so the held keystream is not disturbed.
	assign cfg.ready = 1'b1;

	// The sequencer owns the byte and result handshakes. It raises ready on
	// the byte channel only while a keystream block is held and the result
	// register is free or being emptied in the same cycle. A byte that needs
	// a new block holds its channel while the lanes run the twenty rounds.
	scx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_stream.valid),
		.in_last   (byte_stream.last_byte),
		.in_ready  (byte_stream.ready),
		.out_valid (result_stream.valid),
		.out_ready (result_stream.ready),
		.cmd       (cmd)
	);

	// The datapath keeps the key, nonce and start counter, the sixteen state
	// words that turn into the keystream block, and the result register.
	scx_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.cmd         (cmd),
		.in_data     (byte_stream.data_byte),
		.in_last     (byte_stream.last_byte),
		.result_byte (result_stream.result_byte),
		.result_last (result_stream.result_last)
	);

endmodule
`default_nettype wire
